// File: src/mandelbrot_escape_time_core_macros.svh
// Assertion helpers for the escape-time core.
// Each macro checks one property on the rising edge of clk, disabled while rst_n is low.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH

// Same-cycle implication.
`define MBET_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("escape-time core: same-cycle check failed");

// Next-cycle implication.
`define MBET_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("escape-time core: next-cycle check failed");

`endif

// File: src/mbet_pkg.sv
`default_nettype none

package mbet_pkg;

  // Field widths of the words on the ports.
  localparam int COORD_FIELD_W = 10;
  localparam int PIX_W         = 8;
  localparam int ITER_W        = 10;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 32;

  // Register format of the window registers and the digit size of the multiplier.
  localparam int REG_FRAC    = 28;
  localparam int MUL_DIGIT_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_RE_START = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IM_TOP   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_RE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_IM  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITER = 3'd4;

  // Reset values of the registers.
  localparam logic [31:0]       RST_RE_START = 32'hE000_0000;
  localparam logic [31:0]       RST_IM_TOP   = 32'h1599_999A;
  localparam logic [30:0]       RST_STEP_RE  = 31'd707789;
  localparam logic [30:0]       RST_STEP_IM  = 31'd707789;
  localparam logic [ITER_W-1:0] RST_MAX_ITER = 10'd255;

  typedef struct packed {
    logic [COORD_FIELD_W-1:0] column;
    logic [COORD_FIELD_W-1:0] row;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] iteration_low;
    logic [PIX_W-1:0] green_level;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_MAP_DONE,
    ST_ITER,
    ST_MUL,
    ST_STORE,
    ST_CHECK,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // Which product the shared multiplier is working on.
  typedef enum logic [1:0] {
    PH_RR,
    PH_II,
    PH_RI
  } phase_t;

endpackage

`default_nettype wire

// File: src/mandelbrot_escape_time_core.sv
// Each iteration forms re^2, im^2 and, while the point has not escaped, re*im, one after
// another on the 16-bit digit-serial multiplier that all three products share,
// with ND = ceil((FRAC_BITS+4)/16) digits per product (ND = 2).
// A word is taken only in the idle state, so a new pixel waits until the last is finished.
// Reset: synchronous, active low; clears the sequencer and loads the default window and limit.
`default_nettype none

`include "mandelbrot_escape_time_core_macros.svh"

module mandelbrot_escape_time_core #(
  parameter int FRAC_BITS  = 28,
  parameter int COORD_BITS = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire mbet_pkg::in_word_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output mbet_pkg::out_word_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mbet_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mbet_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import mbet_pkg::*;

  // Working format: signed, FRAC_BITS fraction bits and range [-8, 8).
  localparam int W   = FRAC_BITS + 4;
  // Effective pixel coordinate width; the field itself is fixed.
  localparam int CB  = (COORD_BITS < COORD_FIELD_W) ? COORD_BITS : COORD_FIELD_W;
  // Digit-serial multiplier geometry.
  localparam int DIG = MUL_DIGIT_W;
  localparam int ND  = (W + DIG - 1) / DIG;
  localparam int BW  = ND * DIG;
  localparam int PW  = W + BW;
  localparam int DCW = (ND > 1) ? $clog2(ND) : 1;
  // Mapping adder width and the format conversion.
  localparam int MPW = 31 + CB;
  localparam int SW  = MPW + 2;
  localparam int CW  = W + 32;
  localparam int UP_SHIFT = (FRAC_BITS >= REG_FRAC) ? FRAC_BITS - REG_FRAC : 0;
  localparam int DN_SHIFT = (FRAC_BITS >= REG_FRAC) ? 0 : REG_FRAC - FRAC_BITS;

  localparam logic [W-2:0] WORK_MAX   = {(W-1){1'b1}};
  localparam logic [W-1:0] ESC_BOUND  = {2'b01, {(FRAC_BITS+2){1'b0}}};

  // Saturating add in the working format.
  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return s[W-1:0];
  endfunction

  // Configuration registers.
  logic [31:0]       re_start_r;
  logic [31:0]       im_top_r;
  logic [30:0]       step_re_r;
  logic [30:0]       step_im_r;
  logic [ITER_W-1:0] max_iter_r;

  // Sequencer.
  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [DCW-1:0]    dig_r;
  logic [ITER_W-1:0] count_r;

  // Pixel and orbit registers.
  logic [CB-1:0]  col_r, row_r;
  logic [MPW-1:0] map_prod_r;
  logic [W-1:0]   cre_r, cim_r;
  logic [W-1:0]   zr_r, zi_r;
  logic [W-2:0]   r2_r, i2_r, cross_r;

  // Shared multiplier.
  logic [W-1:0]     ma_r;
  logic [BW-1:0]    mb_r;
  logic [PW-1:0]    prod_r;
  logic [W+DIG-1:0] mul_part;
  logic [PW-1:0]    prod_nxt;
  logic [PW-1:0]    sh_f, sh_c;
  logic [W-2:0]     sat_f, sat_c;

  // Control from the output decoder.
  logic         mul_load;
  logic [W-1:0] mul_a, mul_b;
  logic         out_load;

  logic            out_valid_r;
  out_word_t       out_data_r;

  // Datapath helpers.
  logic [W-1:0]  zr_mag, zi_mag;
  logic [W-1:0]  mag_sum;
  logic          escape;
  logic [W-1:0]  diff, cross_ext, twice;
  logic          neg_cross;
  logic [31:0]   map_base;
  logic [SW-1:0] map_base_ext, map_prod_ext, map_sum;
  logic          map_fits;
  logic [31:0]   q28;
  logic signed [CW-1:0] conv_ext, conv_up, conv_dn;
  logic [CW-1:0]        conv_bias;
  logic [W-1:0]         map_conv;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Magnitudes of z as unsigned working words; the most negative value maps to 2^(W-1).
  assign zr_mag = zr_r[W-1] ? (~zr_r + W'(1)) : zr_r;
  assign zi_mag = zi_r[W-1] ? (~zi_r + W'(1)) : zi_r;

  // Escape test: re^2 + im^2 against 4; both terms stay below 2^(W-1), so no overflow.
  assign mag_sum = {1'b0, r2_r} + {1'b0, i2_r};
  assign escape  = (mag_sum >= ESC_BOUND);

  // Next z. The difference of two nonnegative terms always fits the working format.
  assign diff      = {1'b0, r2_r} - {1'b0, i2_r};
  assign neg_cross = zr_r[W-1] ^ zi_r[W-1];
  assign cross_ext = {1'b0, cross_r};
  assign twice     = neg_cross ? (~cross_ext + W'(1)) : cross_ext;

  // One digit of the product per cycle, most significant digit first.
  assign mul_part = ma_r * mb_r[BW-1 -: DIG];
  assign prod_nxt = (prod_r << DIG) + PW'(mul_part);

  // Scale back and saturate the magnitude: FRAC_BITS for squares, one less for 2*re*im.
  assign sh_f  = prod_r >> FRAC_BITS;
  assign sh_c  = prod_r >> (FRAC_BITS - 1);
  assign sat_f = (|sh_f[PW-1:W-1]) ? WORK_MAX : sh_f[W-2:0];
  assign sat_c = (|sh_c[PW-1:W-1]) ? WORK_MAX : sh_c[W-2:0];

  // Pixel to complex point: the real part is formed in ST_MAP_IM and the imaginary
  // part in ST_MAP_DONE, through one adder. The sum is exact, then clamped to
  // the register format and brought into the working format.
  always_comb begin
    map_base     = (state_r == ST_MAP_IM) ? re_start_r : im_top_r;
    map_base_ext = {{(SW-32){map_base[31]}}, map_base};
    map_prod_ext = {2'b00, map_prod_r};
    if (state_r == ST_MAP_IM) begin
      map_sum = map_base_ext + map_prod_ext;
    end else begin
      map_sum = map_base_ext - map_prod_ext;
    end
    map_fits = (&map_sum[SW-1:31]) || !(|map_sum[SW-1:31]);
    if (map_fits) begin
      q28 = map_sum[31:0];
    end else begin
      q28 = map_sum[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    // Widening is exact; narrowing truncates toward zero, so negative values get a bias.
    conv_ext  = {{W{q28[31]}}, q28};
    conv_up   = conv_ext <<< UP_SHIFT;
    conv_bias = q28[31] ? ((CW'(1) << DN_SHIFT) - CW'(1)) : '0;
    conv_dn   = (conv_ext + $signed(conv_bias)) >>> DN_SHIFT;
    map_conv  = (FRAC_BITS >= REG_FRAC) ? conv_up[W-1:0] : conv_dn[W-1:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MAP_RE;
      end
      ST_MAP_RE:   state_nxt = ST_MAP_IM;
      ST_MAP_IM:   state_nxt = ST_MAP_DONE;
      ST_MAP_DONE: state_nxt = ST_ITER;
      ST_ITER: begin
        state_nxt = (count_r >= max_iter_r) ? ST_FINISH : ST_MUL;
      end
      ST_MUL: begin
        if (dig_r == '0) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        case (phase_r)
          PH_RR:   state_nxt = ST_MUL;
          PH_II:   state_nxt = ST_CHECK;
          PH_RI:   state_nxt = ST_UPDATE;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_CHECK: begin
        state_nxt = escape ? ST_FINISH : ST_MUL;
      end
      ST_UPDATE: state_nxt = ST_ITER;
      ST_FINISH: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs: the multiplier is started for re^2 at the top of an iteration, for
  // im^2 once re^2 is stored, and for re*im once the escape test has passed.
  always_comb begin
    in_ready  = 1'b0;
    mul_load  = 1'b0;
    mul_a     = zr_mag;
    mul_b     = zr_mag;
    phase_nxt = phase_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_ITER: begin
        if (count_r < max_iter_r) begin
          mul_load  = 1'b1;
          phase_nxt = PH_RR;
        end
      end
      ST_STORE: begin
        if (phase_r == PH_RR) begin
          mul_load  = 1'b1;
          mul_a     = zi_mag;
          mul_b     = zi_mag;
          phase_nxt = PH_II;
        end
      end
      ST_CHECK: begin
        if (!escape) begin
          mul_load  = 1'b1;
          mul_b     = zi_mag;
          phase_nxt = PH_RI;
        end
      end
      ST_FINISH: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_RR;
      dig_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      re_start_r  <= RST_RE_START;
      im_top_r    <= RST_IM_TOP;
      step_re_r   <= RST_STEP_RE;
      step_im_r   <= RST_STEP_IM;
      max_iter_r  <= RST_MAX_ITER;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (mul_load) begin
        dig_r <= DCW'(ND - 1);
      end else if (state_r == ST_MUL) begin
        dig_r <= dig_r - DCW'(1);
      end
      if (state_r == ST_MAP_DONE) begin
        count_r <= '0;
      end else if (state_r == ST_UPDATE) begin
        count_r <= count_r + ITER_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RE_START: re_start_r <= cfg_data;
          CFG_IM_TOP:   im_top_r   <= cfg_data;
          CFG_STEP_RE:  step_re_r  <= cfg_data[30:0];
          CFG_STEP_IM:  step_im_r  <= cfg_data[30:0];
          CFG_MAX_ITER: max_iter_r <= cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      col_r <= in_data.column[CB-1:0];
      row_r <= in_data.row[CB-1:0];
    end
    case (state_r)
      ST_MAP_RE: map_prod_r <= col_r * step_re_r;
      ST_MAP_IM: begin
        cre_r      <= map_conv;
        map_prod_r <= row_r * step_im_r;
      end
      ST_MAP_DONE: begin
        cim_r <= map_conv;
        zr_r  <= '0;
        zi_r  <= '0;
      end
      ST_STORE: begin
        case (phase_r)
          PH_RR:   r2_r    <= sat_f;
          PH_II:   i2_r    <= sat_f;
          PH_RI:   cross_r <= sat_c;
          default: ;
        endcase
      end
      ST_UPDATE: begin
        zr_r <= sat_add(diff, cre_r);
        zi_r <= sat_add(twice, cim_r);
      end
      default: ;
    endcase
    if (mul_load) begin
      ma_r   <= mul_a;
      mb_r   <= BW'(mul_b);
      prod_r <= '0;
    end else if (state_r == ST_MUL) begin
      prod_r <= prod_nxt;
      mb_r   <= mb_r << DIG;
    end
    if (out_load) begin
      out_data_r.iteration_low <= count_r[PIX_W-1:0];
      out_data_r.green_level   <= ~count_r[PIX_W-1:0];
    end
  end

  // An accepted word always starts the mapping sequence.
  `MBET_ASSERT_NXT(a_accept_maps, in_valid && in_ready, state_r == ST_MAP_RE)
  // The last digit of a product is always followed by the store step.
  `MBET_ASSERT_NXT(a_mul_to_store, state_r == ST_MUL && dig_r == '0, state_r == ST_STORE)
  // A finished pixel that finds the output register free is presented next cycle.
  `MBET_ASSERT_NXT(a_finish_out, state_r == ST_FINISH && (!out_valid_r || out_ready),
                   out_valid_r && state_r == ST_IDLE)
  // The green level is the complement of the low count bits.
  `MBET_ASSERT_IMP(a_green_level, out_valid_r,
                   out_data_r.green_level == (8'd255 - out_data_r.iteration_low))

endmodule

`default_nettype wire

// File: dv/testbench.sv
module testbench;
  import mbet_pkg::*;

  // The block is built with its default formats; the shading model below
  // follows the same two numbers.
  localparam int FRAC_BITS  = 28;
  localparam int COORD_BITS = 10;
  localparam int WORK_W     = FRAC_BITS + 4;

  // Random phases come in a fixed pattern of eight so that the worst-case
  // run time is known. One slot in each pattern loads raw register values,
  // one zooms in near the set boundary with a deep limit, and one runs with
  // no idling on either side. The others use moderate windows and limits.
  localparam int PHASES     = 24;
  localparam int RAW_SLOT   = 3;
  localparam int DEEP_SLOT  = 6;
  localparam int BURST_SLOT = 7;

  // Cycles to keep watching the output after the last result has arrived.
  localparam int DRAIN_CYCLES = 64;

  // Reported mismatches beyond this count are counted but not printed.
  localparam int REPORT_CAP = 100;

  // All shading arithmetic runs in 128 bits, so the model itself never wraps.
  typedef logic signed [127:0] wide_t;

  localparam wide_t WORK_HI = (wide_t'(1) <<< (WORK_W - 1)) - 1;
  localparam wide_t WORK_LO = -WORK_HI - 1;
  localparam wide_t Q28_HI  = (wide_t'(1) <<< 31) - 1;
  localparam wide_t Q28_LO  = -(wide_t'(1) <<< 31);

  typedef struct {
    in_word_t  pix;
    out_word_t shade;
  } shade_check_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b1;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Our copy of the window registers. They start at the block's reset values
  // and follow every accepted write on the configuration port.
  logic signed [31:0] win_re     = RST_RE_START;
  logic signed [31:0] win_im     = RST_IM_TOP;
  logic [30:0]        step_re_r  = RST_STEP_RE;
  logic [30:0]        step_im_r  = RST_STEP_IM;
  logic [ITER_W-1:0]  iter_limit = RST_MAX_ITER;

  // Pixels waiting for the driver, and shades still owed by the block.
  in_word_t     pixel_queue[$];
  shade_check_t pending_shades[$];

  // Handshake flags captured at the rising edge for use at the falling edge.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  logic out_held  = 1'b0;

  // Idling state of both sides. gap_max is changed only while the block is idle.
  int gap_max   = 6;
  int in_gap    = 0;
  int out_stall = 0;

  int pixels_queued   = 0;
  int pixels_taken    = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int reg_writes      = 0;
  int windows_loaded  = 0;

  mandelbrot_escape_time_core #(
    .FRAC_BITS (FRAC_BITS),
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Shading model
  // ------------------------------------------------------------------------

  function automatic wide_t clamp(input wide_t v, input wide_t lo, input wide_t hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Moves a Q4.28 value into the working format. Going to fewer fraction bits
  // truncates toward zero, which is what signed division does here.
  function automatic wide_t to_work(input wide_t v);
    if (FRAC_BITS >= REG_FRAC) return v <<< (FRAC_BITS - REG_FRAC);
    return v / (wide_t'(1) <<< (REG_FRAC - FRAC_BITS));
  endfunction

  // Product of two magnitudes, shifted down and saturated to the largest
  // positive working value. The right shift drops the low bits, so the
  // magnitude is truncated before any sign is applied.
  function automatic wide_t scaled_product(input wide_t a, input wide_t b, input int sh);
    wide_t p;
    p = (a * b) >>> sh;
    return (p > WORK_HI) ? WORK_HI : p;
  endfunction

  function automatic int escape_count(input in_word_t pix);
    wide_t col, row, origin_re, origin_im, inc_re, inc_im;
    wide_t c_re, c_im, z_re, z_im, m_re, m_im, re_sq, im_sq, prod_ri;
    int    count;
    col       = pix.column;
    row       = pix.row;
    col       = col & ((wide_t'(1) <<< COORD_BITS) - 1);
    row       = row & ((wide_t'(1) <<< COORD_BITS) - 1);
    origin_re = win_re;
    origin_im = win_im;
    inc_re    = step_re_r;
    inc_im    = step_im_r;
    // The point is formed exactly and only then pinned to the Q4.28 range,
    // so a window that runs off the edge collapses onto the boundary.
    c_re  = to_work(clamp(origin_re + col * inc_re, Q28_LO, Q28_HI));
    c_im  = to_work(clamp(origin_im - row * inc_im, Q28_LO, Q28_HI));
    z_re  = 0;
    z_im  = 0;
    count = 0;
    while (count < iter_limit) begin
      m_re  = (z_re < 0) ? -z_re : z_re;
      m_im  = (z_im < 0) ? -z_im : z_im;
      re_sq = scaled_product(m_re, m_re, FRAC_BITS);
      im_sq = scaled_product(m_im, m_im, FRAC_BITS);
      // Escape when |z|^2 reaches 4; the sum of two saturated squares is
      // compared without wrapping.
      if (re_sq + im_sq >= (wide_t'(4) <<< FRAC_BITS)) break;
      // Doubling comes from shifting one bit less.
      prod_ri = scaled_product(m_re, m_im, FRAC_BITS - 1);
      if ((z_re < 0) != (z_im < 0)) prod_ri = -prod_ri;
      z_re  = clamp(re_sq - im_sq + c_re, WORK_LO, WORK_HI);
      z_im  = clamp(prod_ri + c_im, WORK_LO, WORK_HI);
      count++;
    end
    return count;
  endfunction

  // Only the low byte of the count leaves the block; green runs the other way.
  function automatic out_word_t shade_for(input in_word_t pix);
    out_word_t s;
    logic [PIX_W-1:0] low;
    low             = PIX_W'(escape_count(pix));
    s.iteration_low = low;
    s.green_level   = 8'd255 - low;
    return s;
  endfunction

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Everything on the port is sampled here at the rising edge. A pixel word
  // is shaded the moment it is accepted, with the window in force then; the
  // window only changes while nothing is in flight.
  always @(posedge clk) begin : port_monitor
    shade_check_t want;
    in_taken  <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    out_held  <= rst_n && out_valid && !out_ready;
    if (rst_n && in_valid && in_ready) begin
      want.pix   = in_data;
      want.shade = shade_for(in_data);
      pending_shades.push_back(want);
      pixels_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (pending_shades.size() == 0) begin
        report_mismatch($sformatf("result word %0d/%0d with no pixel outstanding",
                                  out_data.iteration_low, out_data.green_level));
      end else begin
        want = pending_shades.pop_front();
        if (out_data.iteration_low !== want.shade.iteration_low)
          report_mismatch($sformatf("pixel (%0d,%0d) iteration_low %0d, expected %0d",
                                    want.pix.column, want.pix.row,
                                    out_data.iteration_low, want.shade.iteration_low));
        if (out_data.green_level !== want.shade.green_level)
          report_mismatch($sformatf("pixel (%0d,%0d) green_level %0d, expected %0d",
                                    want.pix.column, want.pix.row,
                                    out_data.green_level, want.shade.green_level));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Pixel driver and result sink, both moving at the falling edge
  // ------------------------------------------------------------------------

  // A word stays on the port until the edge that takes it. After each word the
  // driver draws how many cycles to rest before offering the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        in_data  <= pixel_queue.pop_front();
        in_valid <= 1'b1;
        in_gap   <= $urandom_range(0, gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // After each result the sink draws a stall. The stall only counts down
  // while a result is actually waiting, so it always lands on a held result.
  always @(negedge clk) begin : result_sink
    int stall;
    if (out_taken) begin
      stall = $urandom_range(0, gap_max);
      out_stall <= stall;
      out_ready <= (stall == 0);
    end else if (out_held && out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= (out_stall == 1);
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  task automatic queue_pixel(input int col, input int row);
    in_word_t pix;
    pix.column = col[COORD_FIELD_W-1:0];
    pix.row    = row[COORD_FIELD_W-1:0];
    pixel_queue.push_back(pix);
    pixels_queued++;
  endtask

  // The block is idle once every queued pixel was taken and every shade came
  // back. Checked at the falling edge, where none of these counts move.
  task automatic wait_drained();
    do @(negedge clk);
    while (pixels_taken != pixels_queued || pending_shades.size() != 0);
  endtask

  // Offers one register write and holds it until taken. Valid stays high into
  // the next write; the caller drops it after the last one.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_RE_START: win_re     = value;
      CFG_IM_TOP:   win_im     = value;
      CFG_STEP_RE:  step_re_r  = value[30:0];
      CFG_STEP_IM:  step_im_r  = value[30:0];
      CFG_MAX_ITER: iter_limit = value[ITER_W-1:0];
      default:      ;
    endcase
    reg_writes++;
  endtask

  // Loads a full window. The unused upper bits of the step and limit writes
  // carry random junk that the block has to mask off, and a last write to an
  // index past the register list must leave everything as it was.
  task automatic load_window(input logic [31:0] re0, input logic [31:0] im0,
                             input logic [30:0] sre, input logic [30:0] sim,
                             input logic [ITER_W-1:0] lim);
    write_reg(CFG_RE_START, re0);
    write_reg(CFG_IM_TOP, im0);
    write_reg(CFG_STEP_RE, {1'($urandom), sre});
    write_reg(CFG_STEP_IM, {1'($urandom), sim});
    write_reg(CFG_MAX_ITER, {22'($urandom), lim});
    write_reg(CFG_MAX_ITER + 3'($urandom_range(1, 3)), $urandom);
    @(negedge clk);
    cfg_valid <= 1'b0;
    windows_loaded++;
  endtask

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------

  initial begin : stimulus
    int                 items;
    logic signed [31:0] re0, im0;
    logic [30:0]        sre, sim;
    logic [ITER_W-1:0]  lim;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Default window straight out of reset: the corners of the field range,
    // a point on the real axis inside the main cardioid that runs to the
    // limit, and a couple of points near the boundary.
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(0, 1023);
    queue_pixel(1023, 0);
    queue_pixel(512, 512);
    queue_pixel(200, 100);
    queue_pixel(700, 300);
    wait_drained();

    // A zero limit means no iteration at all, wherever the point lies.
    load_window(RST_RE_START, RST_IM_TOP, RST_STEP_RE, RST_STEP_IM, '0);
    queue_pixel(512, 512);
    queue_pixel(1023, 0);
    wait_drained();

    // Every pixel maps to the origin and never escapes. The full limit gives
    // a count whose low byte is all ones; a limit of 256 wraps the byte to zero.
    load_window('0, '0, '0, '0, '1);
    queue_pixel(5, 9);
    wait_drained();
    load_window('0, '0, '0, '0, ITER_W'(256));
    queue_pixel(1023, 1023);
    wait_drained();

    // Largest origin and largest steps: the point pins to the edge of the
    // Q4.28 range, high or low depending on the pixel.
    load_window(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, ITER_W'(5));
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(1023, 0);
    queue_pixel(0, 1023);
    wait_drained();

    // Same from the most negative origin.
    load_window(32'h8000_0000, 32'h8000_0000, '1, '1, ITER_W'(9));
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(1023, 0);
    queue_pixel(0, 1023);
    wait_drained();

    // Random windows. The ordinary ones cover roughly [-2.25, 0.25] for the
    // left edge and [-0.25, 1.5] for the top, with steps of up to about 4/1024.
    for (int p = 0; p < PHASES; p++) begin
      gap_max = 6;
      items   = 106;
      re0     = int'($urandom_range(0, 671088640)) - 603979776;
      im0     = int'($urandom_range(0, 469762048)) - 67108864;
      sre     = 31'($urandom_range(0, 1 << 20));
      sim     = 31'($urandom_range(0, 1 << 20));
      lim     = ITER_W'($urandom_range(0, 48));
      case (p % 8)
        RAW_SLOT: begin
          // Raw register values: mostly far-out points that escape at once,
          // and any limit the field allows. Few pixels, since one that stays
          // in can take the whole limit.
          re0   = $urandom;
          im0   = $urandom;
          sre   = 31'($urandom);
          sim   = 31'($urandom);
          lim   = ITER_W'($urandom);
          items = 8;
        end
        DEEP_SLOT: begin
          // Small window near the cardioid neck at -0.75, where counts spread
          // widely and many points run the full limit.
          re0   = int'($urandom_range(0, 1 << 24)) - 201326592;
          im0   = $urandom_range(0, 1 << 26);
          sre   = 31'($urandom_range(0, 1 << 14));
          sim   = 31'($urandom_range(0, 1 << 14));
          lim   = ITER_W'(255);
          items = 24;
        end
        BURST_SLOT: begin
          gap_max = 0;
          lim     = ITER_W'($urandom_range(0, 32));
          items   = 80;
        end
        default: ;
      endcase
      load_window(re0, im0, sre, sim, lim);
      repeat (items) queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      wait_drained();
    end

    // Nothing is outstanding now; anything the block still emits is caught
    // by the monitor as a result with no pixel behind it.
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Shaded %0d pixels over %0d windows with %0d register writes.",
             pixels_taken, windows_loaded, reg_writes);
    $display("Compared %0d result words, %0d field mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // The slowest legal run has every pixel taking its full limit and both
  // sides resting as long as they may; this watchdog stops a run that hangs.
  initial begin
    #100_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/mbet_pkg.sv
src/mandelbrot_escape_time_core.sv
dv/testbench.sv
